@@ hw/rtl/vdt_pkg.sv @@
// vertex dedup table package: table size, derived widths and word types
// used by vertex_dedup_table_top; depends on nothing
`default_nettype none

package vdt_pkg;

   localparam int MAX_DISTINCT = 256;
   localparam int ADDR_W       = (MAX_DISTINCT > 2) ? $clog2(MAX_DISTINCT) : 1;
   localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);
   localparam int COORD_W      = 32;
   localparam int TOL_W        = 31;
   localparam int ID_W         = 8;
   localparam int TOTAL_W      = 9;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [TOL_W-1:0]          tol_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [ID_W-1:0]           id_type;
   typedef logic [TOTAL_W-1:0]        total_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   // low bits of an entry index, as the result word carries them
   function automatic id_type to_id(input cnt_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[ID_W-1:0];
   endfunction

   function automatic total_type to_total(input cnt_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[TOTAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vertex_dedup_table_top.sv @@
// Vertex dedup table: holds up to MAX_DISTINCT distinct vertices in one
// synchronous memory and gives each incoming vertex the id of the first stored
// vertex within the tolerance on every axis, or appends it under a new id, or
// flags an overflow when the table is full. One vertex is handled at a time:
// the stored entries are read in order from entry 0 until the first match or
// the last entry, and a stalled earlier result holding the output register
// delays the new one. req_stall stays high from acceptance until the result
// has moved into the output register. The scan is paced by the single memory
// read port, which delivers one stored vertex per cycle to the three
// comparators.
// A set flag empties the table at once; no clearing pass is needed after reset.
// Depends on vdt_pkg.
`default_nettype none

module vertex_dedup_table_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire vdt_pkg::tol_type  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vdt_pkg::coord_type req_pos_x,
   input  wire vdt_pkg::coord_type req_pos_y,
   input  wire vdt_pkg::coord_type req_pos_z,
   input  wire logic              req_start_set,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vdt_pkg::id_type        rsp_vertex_id,
   output logic                   rsp_is_new,
   output vdt_pkg::total_type     rsp_distinct_total,
   output logic                   rsp_overflow
);
   import vdt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   localparam cnt_type TABLE_FULL = CNT_W'(MAX_DISTINCT);

   vertex_type mem [MAX_DISTINCT];

   state_type  state_ff,   state_in;
   tol_type    tol_ff,     tol_in;
   vertex_type vtx_ff,     vtx_in;
   cnt_type    count_ff,   count_in;
   cnt_type    issue_ff,   issue_in;
   logic       cmp_vld_ff, cmp_vld_in;
   cnt_type    cmp_idx_ff, cmp_idx_in;
   vertex_type rd_data_ff;

   id_type     res_id_ff,    res_id_in;
   logic       res_new_ff,   res_new_in;
   total_type  res_total_ff, res_total_in;
   logic       res_ovf_ff,   res_ovf_in;

   logic       out_vld_ff,   out_vld_in;
   id_type     out_id_ff,    out_id_in;
   logic       out_new_ff,   out_new_in;
   total_type  out_total_ff, out_total_in;
   logic       out_ovf_ff,   out_ovf_in;

   logic       rd_en;
   logic       wr_en;
   logic       hit;
   logic       accept;
   logic       out_free;

   // |a - b| <= t without a negation: a <= b + t and b <= a + t
   function automatic logic near(input coord_type a, input coord_type b,
                                 input tol_type t);
      logic signed [COORD_W+1:0] a_w;
      logic signed [COORD_W+1:0] b_w;
      logic signed [COORD_W+1:0] t_w;
      a_w = (COORD_W+2)'(a);
      b_w = (COORD_W+2)'(b);
      t_w = $signed({3'b000, t});
      return (a_w <= b_w + t_w) && (b_w <= a_w + t_w);
   endfunction

   assign hit = cmp_vld_ff
              && near(vtx_ff.x, rd_data_ff.x, tol_ff)
              && near(vtx_ff.y, rd_data_ff.y, tol_ff)
              && near(vtx_ff.z, rd_data_ff.z, tol_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_vld_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      tol_in       = csr_wr_en ? csr_wr_data : tol_ff;
      vtx_in       = vtx_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      res_id_in    = res_id_ff;
      res_new_in   = res_new_ff;
      res_total_in = res_total_ff;
      res_ovf_in   = res_ovf_ff;
      out_vld_in   = out_vld_ff && rsp_stall;
      out_id_in    = out_id_ff;
      out_new_in   = out_new_ff;
      out_total_in = out_total_ff;
      out_ovf_in   = out_ovf_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vtx_in.x = req_pos_x;
               vtx_in.y = req_pos_y;
               vtx_in.z = req_pos_z;
               if (req_start_set) begin
                  count_in = '0;
               end
               issue_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_id_in    = to_id(cmp_idx_ff);
               res_new_in   = 1'b0;
               res_total_in = to_total(count_ff);
               res_ovf_in   = 1'b0;
               state_in     = S_EMIT;
            end else if (!cmp_vld_ff && (issue_ff == count_ff)) begin
               // every stored entry compared, none close enough
               if (count_ff < TABLE_FULL) begin
                  wr_en        = 1'b1;
                  res_id_in    = to_id(count_ff);
                  res_new_in   = 1'b1;
                  res_total_in = to_total(count_ff + 1'b1);
                  res_ovf_in   = 1'b0;
                  count_in     = count_ff + 1'b1;
               end else begin
                  res_id_in    = '0;
                  res_new_in   = 1'b0;
                  res_total_in = to_total(count_ff);
                  res_ovf_in   = 1'b1;
               end
               state_in = S_EMIT;
            end else if (issue_ff != count_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff;
               issue_in   = issue_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_id_in    = res_id_ff;
               out_new_in   = res_new_ff;
               out_total_in = res_total_ff;
               out_ovf_in   = res_ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tol_ff     <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tol_ff     <= tol_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff       <= vtx_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_id_ff    <= res_id_in;
      res_new_ff   <= res_new_in;
      res_total_ff <= res_total_in;
      res_ovf_ff   <= res_ovf_in;
      out_id_ff    <= out_id_in;
      out_new_ff   <= out_new_in;
      out_total_ff <= out_total_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // vertex store, one read port and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= vtx_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_vertex_id      = out_id_ff;
   assign rsp_is_new         = out_new_ff;
   assign rsp_distinct_total = out_total_ff;
   assign rsp_overflow       = out_ovf_ff;

endmodule

`default_nettype wire
